// ----- rtl/matrix_cipher_3x3_unit_assert.svh -----
// Assertion macros for the matrix cipher unit
`ifndef MATRIX_CIPHER_3X3_UNIT_ASSERT_SVH
`define MATRIX_CIPHER_3X3_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define MC3_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("mc3 assertion failed");
`define MC3_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("mc3 forbidden condition seen");
`else
`define MC3_ASSERT(label, clk, rst_n, prop)
`define MC3_NEVER(label, clk, rst_n, expr)
`endif
`endif

// ----- rtl/mc3_pkg.sv -----
// Shared widths, codes and types of the matrix cipher unit
package mc3_pkg;

  localparam int KEY_W     = 24;
  localparam int ENTRY_W   = 8;
  localparam int ELEM_W    = 16;
  localparam int COEF_W    = 17;
  localparam int PROD_W    = 33;
  localparam int VALUE_W   = 35;
  localparam int LETTER_W  = 7;
  localparam int COF_W     = 17;
  localparam int DET_W     = 27;
  localparam int QUOT_W    = 16;
  localparam int STEP_W    = 4;
  localparam int CFG_IDX_W = 2;

  localparam int LETTER_BASE  = 65;
  localparam int ALPHABET_LEN = 26;
  localparam int CASE_GAP     = 32;

  localparam logic [KEY_W-1:0] KEY_ROW_ZERO_RST = 24'h030201;
  localparam logic [KEY_W-1:0] KEY_ROW_ONE_RST  = 24'h020101;
  localparam logic [KEY_W-1:0] KEY_ROW_TWO_RST  = 24'h020100;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_ROW_ZERO = 2'd0,
    CFG_KEY_ROW_ONE  = 2'd1,
    CFG_KEY_ROW_TWO  = 2'd2
  } cfg_index_e;

  typedef enum logic [1:0] {
    INV_IDLE,
    INV_COF,
    INV_DET,
    INV_DIV
  } inv_state_e;

  typedef enum logic {
    CMD_ENCRYPT = 1'b0,
    CMD_DECRYPT = 1'b1
  } command_e;

  typedef logic [2:0][KEY_W-1:0] key_t;

  // inverse matrix, row major, with its status
  typedef struct packed {
    logic                     busy;
    logic                     singular;
    logic [8:0][COEF_W-1:0]   coef;
  } inv_t;

  function automatic logic signed [ENTRY_W-1:0] key_entry(key_t key, int row, int col);
    key_entry = key[row][ENTRY_W*col +: ENTRY_W];
  endfunction

endpackage

// ----- rtl/matrix_cipher_3x3_unit.sv -----
// Matrix cipher unit: 3x3 key multiply for encrypt, integer inverse multiply for decrypt
// One triplet is taken per cycle while busy is low; once taken, its result passes
// the stage registers s1 to s4 and appears on result_valid_o for one cycle, and cannot be
// held off. The four stages are decode, multiply, sum and letter mapping. After
// reset and after every key register write the key inverse is rebuilt by nine
// parallel bit-serial dividers, one quotient bit a cycle: busy stays high while
// that runs, and key writes are taken at any time.
module matrix_cipher_3x3_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 command_i,
  input  logic signed [mc3_pkg::ELEM_W-1:0]    elem_zero_i,
  input  logic signed [mc3_pkg::ELEM_W-1:0]    elem_one_i,
  input  logic signed [mc3_pkg::ELEM_W-1:0]    elem_two_i,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic        [mc3_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic        [mc3_pkg::KEY_W-1:0]     cfg_data_i,
  output logic                                 result_valid_o,
  output logic signed [mc3_pkg::VALUE_W-1:0]   value_zero_o,
  output logic signed [mc3_pkg::VALUE_W-1:0]   value_one_o,
  output logic signed [mc3_pkg::VALUE_W-1:0]   value_two_o,
  output logic        [mc3_pkg::LETTER_W-1:0]  letter_zero_o,
  output logic        [mc3_pkg::LETTER_W-1:0]  letter_one_o,
  output logic        [mc3_pkg::LETTER_W-1:0]  letter_two_o,
  output logic                                 key_singular_o,
  output logic                                 bad_letter_o
);

`include "matrix_cipher_3x3_unit_assert.svh"

  mc3_pkg::key_t key_q;
  mc3_pkg::inv_t inv;
  logic          cfg_write;
  logic          accept;

  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i & cfg_ready_o;
  assign busy        = inv.busy | cfg_write;
  assign accept      = start & ~busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q[0] <= mc3_pkg::KEY_ROW_ZERO_RST;
      key_q[1] <= mc3_pkg::KEY_ROW_ONE_RST;
      key_q[2] <= mc3_pkg::KEY_ROW_TWO_RST;
    end else if (cfg_write) begin
      case (cfg_index_i)
        mc3_pkg::CFG_KEY_ROW_ZERO: key_q[0] <= cfg_data_i;
        mc3_pkg::CFG_KEY_ROW_ONE:  key_q[1] <= cfg_data_i;
        mc3_pkg::CFG_KEY_ROW_TWO:  key_q[2] <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  mc3_inverse u_inverse (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .key_i     (key_q),
    .restart_i (cfg_write),
    .inv_o     (inv)
  );

  mc3_pipe u_pipe (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .command_i      (command_i),
    .elem_zero_i    (elem_zero_i),
    .elem_one_i     (elem_one_i),
    .elem_two_i     (elem_two_i),
    .key_i          (key_q),
    .inv_i          (inv),
    .valid_o        (result_valid_o),
    .value_zero_o   (value_zero_o),
    .value_one_o    (value_one_o),
    .value_two_o    (value_two_o),
    .letter_zero_o  (letter_zero_o),
    .letter_one_o   (letter_one_o),
    .letter_two_o   (letter_two_o),
    .key_singular_o (key_singular_o),
    .bad_letter_o   (bad_letter_o)
  );

  // every accepted transaction leaves the pipeline on result_valid_o
  `MC3_ASSERT(a_latency, clk_i, rst_ni, (start && !busy) |-> ##4 result_valid_o)
  `MC3_ASSERT(a_no_phantom, clk_i, rst_ni, result_valid_o |-> $past(start && !busy, 4))
  `MC3_ASSERT(a_write_busy, clk_i, rst_ni, cfg_write |=> busy)
  `MC3_NEVER(a_flag_mix, clk_i, rst_ni,
             result_valid_o && bad_letter_o && (|{letter_zero_o, letter_one_o, letter_two_o}))

endmodule

// ----- rtl/mc3_inverse.sv -----
// Integer inverse of the key: cofactors, determinant and bit-serial division lanes
module mc3_inverse (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  mc3_pkg::key_t key_i,
  input  logic          restart_i,
  output mc3_pkg::inv_t inv_o
);

  mc3_pkg::inv_state_e state_q, state_d;

  logic signed [mc3_pkg::COF_W-1:0]  cof_q [9];
  logic signed [mc3_pkg::COF_W-1:0]  cof_d [9];
  logic        [mc3_pkg::DET_W-1:0]  div_q;
  logic                              det_neg_q;
  logic                              singular_q;
  logic signed [mc3_pkg::DET_W-1:0]  det_d;
  logic        [mc3_pkg::QUOT_W-1:0] num_q  [9];
  logic        [mc3_pkg::QUOT_W-1:0] quot_q [9];
  logic        [mc3_pkg::DET_W-1:0]  rem_q  [9];
  logic        [mc3_pkg::DET_W-1:0]  rem_d  [9];
  logic                              qbit_d [9];
  logic        [mc3_pkg::COEF_W-1:0] coef_q [9];
  logic        [mc3_pkg::STEP_W-1:0] cnt_q;

  // cofactors C[i][j]
  always_comb begin
    int r0, r1, c0, c1;
    logic signed [mc3_pkg::COF_W-1:0] minor;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        r0 = (i == 0) ? 1 : 0;
        r1 = (i == 2) ? 1 : 2;
        c0 = (j == 0) ? 1 : 0;
        c1 = (j == 2) ? 1 : 2;
        minor = mc3_pkg::COF_W'(mc3_pkg::key_entry(key_i, r0, c0)
                                * mc3_pkg::key_entry(key_i, r1, c1))
              - mc3_pkg::COF_W'(mc3_pkg::key_entry(key_i, r0, c1)
                                * mc3_pkg::key_entry(key_i, r1, c0));
        cof_d[3*i+j] = (((i + j) % 2) == 1) ? -minor : minor;
      end
    end
  end

  always_comb begin
    det_d = mc3_pkg::DET_W'(mc3_pkg::key_entry(key_i, 0, 0) * cof_q[0])
          + mc3_pkg::DET_W'(mc3_pkg::key_entry(key_i, 0, 1) * cof_q[1])
          + mc3_pkg::DET_W'(mc3_pkg::key_entry(key_i, 0, 2) * cof_q[2]);
  end

  // one restoring step per lane
  always_comb begin
    logic [mc3_pkg::DET_W:0] trial;
    for (int n = 0; n < 9; n++) begin
      trial = {rem_q[n], num_q[n][mc3_pkg::QUOT_W-1]};
      if (trial >= {1'b0, div_q}) begin
        rem_d[n]  = mc3_pkg::DET_W'(trial - {1'b0, div_q});
        qbit_d[n] = 1'b1;
      end else begin
        rem_d[n]  = trial[mc3_pkg::DET_W-1:0];
        qbit_d[n] = 1'b0;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      mc3_pkg::INV_IDLE: state_d = mc3_pkg::INV_IDLE;
      mc3_pkg::INV_COF:  state_d = mc3_pkg::INV_DET;
      mc3_pkg::INV_DET:  state_d = mc3_pkg::INV_DIV;
      mc3_pkg::INV_DIV: begin
        if (cnt_q == {mc3_pkg::STEP_W{1'b1}}) state_d = mc3_pkg::INV_IDLE;
      end
      default: state_d = mc3_pkg::INV_IDLE;
    endcase
    if (restart_i) state_d = mc3_pkg::INV_COF;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mc3_pkg::INV_COF;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == mc3_pkg::INV_DIV) cnt_q <= cnt_q + 1'b1;
      else                              cnt_q <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    logic [mc3_pkg::QUOT_W-1:0] qfin;
    logic                       neg;
    case (state_q)
      mc3_pkg::INV_COF: begin
        for (int n = 0; n < 9; n++) cof_q[n] <= cof_d[n];
      end
      mc3_pkg::INV_DET: begin
        det_neg_q  <= det_d[mc3_pkg::DET_W-1];
        singular_q <= (det_d == '0);
        div_q      <= det_d[mc3_pkg::DET_W-1] ? mc3_pkg::DET_W'(-det_d)
                                              : mc3_pkg::DET_W'(det_d);
        // lane 3i+j divides C[j][i]
        for (int i = 0; i < 3; i++) begin
          for (int j = 0; j < 3; j++) begin
            num_q[3*i+j] <= cof_q[3*j+i][mc3_pkg::COF_W-1]
                          ? mc3_pkg::QUOT_W'(-cof_q[3*j+i])
                          : mc3_pkg::QUOT_W'(cof_q[3*j+i]);
            rem_q[3*i+j]  <= '0;
            quot_q[3*i+j] <= '0;
          end
        end
      end
      mc3_pkg::INV_DIV: begin
        for (int i = 0; i < 3; i++) begin
          for (int j = 0; j < 3; j++) begin
            qfin = {quot_q[3*i+j][mc3_pkg::QUOT_W-2:0], qbit_d[3*i+j]};
            neg  = cof_q[3*j+i][mc3_pkg::COF_W-1] ^ det_neg_q;
            rem_q[3*i+j]  <= rem_d[3*i+j];
            num_q[3*i+j]  <= {num_q[3*i+j][mc3_pkg::QUOT_W-2:0], 1'b0};
            quot_q[3*i+j] <= qfin;
            if (cnt_q == {mc3_pkg::STEP_W{1'b1}}) begin
              // truncate toward zero: negate the magnitude
              coef_q[3*i+j] <= neg ? mc3_pkg::COEF_W'(-{1'b0, qfin})
                                   : {1'b0, qfin};
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    inv_o.busy     = (state_q != mc3_pkg::INV_IDLE);
    inv_o.singular = singular_q;
    for (int n = 0; n < 9; n++) inv_o.coef[n] = coef_q[n];
  end

endmodule

// ----- rtl/mc3_pipe.sv -----
// Four-stage cipher pipeline: decode, multiply, sum, letter mapping
module mc3_pipe (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 accept_i,
  input  logic                                 command_i,
  input  logic signed [mc3_pkg::ELEM_W-1:0]    elem_zero_i,
  input  logic signed [mc3_pkg::ELEM_W-1:0]    elem_one_i,
  input  logic signed [mc3_pkg::ELEM_W-1:0]    elem_two_i,
  input  mc3_pkg::key_t                        key_i,
  input  mc3_pkg::inv_t                        inv_i,
  output logic                                 valid_o,
  output logic signed [mc3_pkg::VALUE_W-1:0]   value_zero_o,
  output logic signed [mc3_pkg::VALUE_W-1:0]   value_one_o,
  output logic signed [mc3_pkg::VALUE_W-1:0]   value_two_o,
  output logic        [mc3_pkg::LETTER_W-1:0]  letter_zero_o,
  output logic        [mc3_pkg::LETTER_W-1:0]  letter_one_o,
  output logic        [mc3_pkg::LETTER_W-1:0]  letter_two_o,
  output logic                                 key_singular_o,
  output logic                                 bad_letter_o
);

  logic signed [mc3_pkg::ELEM_W-1:0]  elem [3];
  logic signed [mc3_pkg::ELEM_W-1:0]  vec_d [3];
  logic                               bad_d;
  logic signed [mc3_pkg::COEF_W-1:0]  coef_d [9];

  logic                               s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q;
  logic                               s1_dec_q, s2_dec_q, s3_dec_q;
  logic                               s1_bad_q, s2_bad_q, s3_bad_q, s4_bad_q;
  logic                               s1_sing_q, s2_sing_q, s3_sing_q, s4_sing_q;
  logic signed [mc3_pkg::ELEM_W-1:0]  s1_vec_q [3];
  logic signed [mc3_pkg::COEF_W-1:0]  s1_coef_q [9];
  logic signed [mc3_pkg::PROD_W-1:0]  s2_prod_q [9];
  logic signed [mc3_pkg::VALUE_W-1:0] s3_sum_q [3];
  logic signed [mc3_pkg::VALUE_W-1:0] s4_val_q [3];
  logic        [mc3_pkg::LETTER_W-1:0] s4_let_q [3];
  logic                               dec;

  assign elem[0] = elem_zero_i;
  assign elem[1] = elem_one_i;
  assign elem[2] = elem_two_i;
  assign dec = (command_i == mc3_pkg::CMD_DECRYPT);

  // encrypt maps letters to codes 1..26, anything else to 0 and flagged; decrypt passes elements through
  always_comb begin
    bad_d = 1'b0;
    for (int n = 0; n < 3; n++) begin
      if (dec) begin
        vec_d[n] = elem[n];
      end else if (elem[n] >= 16'sd65 && elem[n] <= 16'sd90) begin
        vec_d[n] = mc3_pkg::ELEM_W'(elem[n] - 16'sd64);
      end else if (elem[n] >= 16'sd97 && elem[n] <= 16'sd122) begin
        vec_d[n] = mc3_pkg::ELEM_W'(elem[n] - 16'sd96);
      end else begin
        vec_d[n] = '0;
        bad_d    = 1'b1;
      end
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (!dec)               coef_d[3*i+j] = mc3_pkg::COEF_W'(mc3_pkg::key_entry(key_i, i, j));
        else if (inv_i.singular) coef_d[3*i+j] = '0;
        else                    coef_d[3*i+j] = inv_i.coef[3*i+j];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_dec_q  <= dec;
    s1_bad_q  <= bad_d & ~dec;
    s1_sing_q <= inv_i.singular;
    for (int n = 0; n < 3; n++) s1_vec_q[n] <= vec_d[n];
    for (int n = 0; n < 9; n++) s1_coef_q[n] <= coef_d[n];

    s2_dec_q  <= s1_dec_q;
    s2_bad_q  <= s1_bad_q;
    s2_sing_q <= s1_sing_q;
    for (int n = 0; n < 9; n++) s2_prod_q[n] <= s1_coef_q[n] * s1_vec_q[n % 3];

    s3_dec_q  <= s2_dec_q;
    s3_bad_q  <= s2_bad_q;
    s3_sing_q <= s2_sing_q;
    for (int i = 0; i < 3; i++) begin
      s3_sum_q[i] <= mc3_pkg::VALUE_W'(s2_prod_q[3*i])
                   + mc3_pkg::VALUE_W'(s2_prod_q[3*i+1])
                   + mc3_pkg::VALUE_W'(s2_prod_q[3*i+2]);
    end

    s4_bad_q  <= s3_bad_q;
    s4_sing_q <= s3_sing_q;
    for (int i = 0; i < 3; i++) begin
      s4_val_q[i] <= s3_sum_q[i];
      if (s3_dec_q && s3_sum_q[i] >= 35'sd1 && s3_sum_q[i] <= 35'sd26) begin
        s4_let_q[i] <= s3_sum_q[i][mc3_pkg::LETTER_W-1:0]
                     + mc3_pkg::LETTER_W'(mc3_pkg::LETTER_BASE - 1);
      end else begin
        s4_let_q[i] <= '0;
      end
    end
  end

  assign valid_o        = s4_valid_q;
  assign value_zero_o   = s4_val_q[0];
  assign value_one_o    = s4_val_q[1];
  assign value_two_o    = s4_val_q[2];
  assign letter_zero_o  = s4_let_q[0];
  assign letter_one_o   = s4_let_q[1];
  assign letter_two_o   = s4_let_q[2];
  assign key_singular_o = s4_sing_q;
  assign bad_letter_o   = s4_bad_q;

endmodule

// ----- test/tb_matrix_cipher_3x3_unit.sv -----
// Self-checking testbench for the 3x3 matrix cipher unit
`timescale 1ns / 1ps
module tb_matrix_cipher_3x3_unit;

  typedef struct {
    mc3_pkg::command_e  cmd;
    logic signed [15:0] e0, e1, e2;
  } triplet_t;

  typedef struct {
    logic signed [mc3_pkg::VALUE_W-1:0] v0, v1, v2;
    logic [mc3_pkg::LETTER_W-1:0]       l0, l1, l2;
    logic                               singular, bad;
  } cipher_out_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic command_i = 1'b0;
  logic signed [mc3_pkg::ELEM_W-1:0] elem_zero_i = '0, elem_one_i = '0, elem_two_i = '0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [mc3_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [mc3_pkg::KEY_W-1:0] cfg_data_i = '0;
  logic result_valid_o;
  logic signed [mc3_pkg::VALUE_W-1:0] value_zero_o, value_one_o, value_two_o;
  logic [mc3_pkg::LETTER_W-1:0] letter_zero_o, letter_one_o, letter_two_o;
  logic key_singular_o, bad_letter_o;

  logic [mc3_pkg::KEY_W-1:0] key_rows [3];
  triplet_t    pending_q [$];
  cipher_out_t expected_q [$];
  cipher_out_t staged_out;
  int  idle_pct = 20;
  bit  hold = 1'b1;
  int  errors = 0;

  matrix_cipher_3x3_unit dut (.*);

  always #4 clk_i = ~clk_i;

  function automatic longint letter_code(longint c, ref logic bad);
    if (c >= mc3_pkg::LETTER_BASE && c < mc3_pkg::LETTER_BASE + mc3_pkg::ALPHABET_LEN)
      return c - mc3_pkg::LETTER_BASE + 1;
    if (c >= mc3_pkg::LETTER_BASE + mc3_pkg::CASE_GAP &&
        c < mc3_pkg::LETTER_BASE + mc3_pkg::CASE_GAP + mc3_pkg::ALPHABET_LEN)
      return c - mc3_pkg::LETTER_BASE - mc3_pkg::CASE_GAP + 1;
    bad = 1'b1;
    return 0;
  endfunction

  function automatic cipher_out_t cipher_predict(triplet_t t);
    longint k [3][3];
    longint cof [3][3];
    longint x [3];
    longint r [3];
    longint det;
    logic [mc3_pkg::LETTER_W-1:0] l [3];
    cipher_out_t o;
    o.bad = 1'b0;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        k[i][j] = longint'($signed(key_rows[i][8*j +: 8]));
    // cyclic index form carries the cofactor sign
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        cof[i][j] = k[(i+1)%3][(j+1)%3] * k[(i+2)%3][(j+2)%3]
                  - k[(i+1)%3][(j+2)%3] * k[(i+2)%3][(j+1)%3];
    det = k[0][0]*cof[0][0] + k[0][1]*cof[0][1] + k[0][2]*cof[0][2];
    x[0] = t.e0; x[1] = t.e1; x[2] = t.e2;
    for (int i = 0; i < 3; i++) begin
      r[i] = 0;
      l[i] = '0;
    end
    if (t.cmd == mc3_pkg::CMD_ENCRYPT) begin
      for (int i = 0; i < 3; i++) x[i] = letter_code(x[i], o.bad);
      for (int i = 0; i < 3; i++) r[i] = k[i][0]*x[0] + k[i][1]*x[1] + k[i][2]*x[2];
    end else if (det != 0) begin
      for (int i = 0; i < 3; i++) begin
        r[i] = (cof[0][i] / det) * x[0] + (cof[1][i] / det) * x[1]
             + (cof[2][i] / det) * x[2];
        if (r[i] >= 1 && r[i] <= mc3_pkg::ALPHABET_LEN)
          l[i] = mc3_pkg::LETTER_W'(r[i] - 1 + mc3_pkg::LETTER_BASE);
      end
    end
    o.v0 = mc3_pkg::VALUE_W'(r[0]);
    o.v1 = mc3_pkg::VALUE_W'(r[1]);
    o.v2 = mc3_pkg::VALUE_W'(r[2]);
    o.l0 = l[0]; o.l1 = l[1]; o.l2 = l[2];
    o.singular = (det == 0);
    return o;
  endfunction

  function automatic void add_triplet(mc3_pkg::command_e c, int a, int b, int d);
    triplet_t t;
    t.cmd = c;
    t.e0 = mc3_pkg::ELEM_W'(a);
    t.e1 = mc3_pkg::ELEM_W'(b);
    t.e2 = mc3_pkg::ELEM_W'(d);
    pending_q.push_back(t);
  endfunction

  function automatic int rand_char();
    case ($urandom_range(9))
      0:       return $urandom_range(65535);
      1:       return $urandom_range(127);
      2, 3, 4: return mc3_pkg::LETTER_BASE + mc3_pkg::CASE_GAP
                      + $urandom_range(mc3_pkg::ALPHABET_LEN - 1);
      default: return mc3_pkg::LETTER_BASE + $urandom_range(mc3_pkg::ALPHABET_LEN - 1);
    endcase
  endfunction

  // Driver: push the expectation when a transaction is taken, then offer the next
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) expected_q.push_back(staged_out);
      if (!start || !busy) begin
        if (!hold && pending_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
          triplet_t t;
          t = pending_q.pop_front();
          staged_out <= cipher_predict(t);
          command_i <= t.cmd;
          elem_zero_i <= t.e0;
          elem_one_i <= t.e1;
          elem_two_i <= t.e2;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // Monitor
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (expected_q.size() == 0) begin
        $error("result with no transaction outstanding");
        errors++;
      end else begin
        cipher_out_t e;
        e = expected_q.pop_front();
        check_field("value_zero", e.v0, value_zero_o);
        check_field("value_one", e.v1, value_one_o);
        check_field("value_two", e.v2, value_two_o);
        check_field("letter_zero", e.l0, letter_zero_o);
        check_field("letter_one", e.l1, letter_one_o);
        check_field("letter_two", e.l2, letter_two_o);
        check_field("key_singular", e.singular, key_singular_o);
        check_field("bad_letter", e.bad, bad_letter_o);
      end
    end
  end

  task automatic drain();
    hold = 1'b0;
    while (pending_q.size() > 0 || start || expected_q.size() > 0) @(posedge clk_i);
    hold = 1'b1;
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_key(mc3_pkg::cfg_index_e idx, logic [mc3_pkg::KEY_W-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    key_rows[idx] = data;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic load_key(logic [mc3_pkg::KEY_W-1:0] r0, r1, r2);
    write_key(mc3_pkg::CFG_KEY_ROW_ZERO, r0);
    write_key(mc3_pkg::CFG_KEY_ROW_ONE, r1);
    write_key(mc3_pkg::CFG_KEY_ROW_TWO, r2);
  endtask

  task automatic random_phase(int count);
    cipher_out_t enc;
    triplet_t t;
    for (int n = 0; n < count; n++) begin
      t.cmd = mc3_pkg::CMD_ENCRYPT;
      t.e0 = mc3_pkg::ELEM_W'(rand_char());
      t.e1 = mc3_pkg::ELEM_W'(rand_char());
      t.e2 = mc3_pkg::ELEM_W'(rand_char());
      case ($urandom_range(3))
        0: add_triplet(mc3_pkg::CMD_ENCRYPT, t.e0, t.e1, t.e2);
        1: add_triplet(mc3_pkg::CMD_DECRYPT, $urandom_range(65535), $urandom_range(65535),
                       $urandom_range(65535));
        default: begin
          // round trip: decrypt the cipher codes of a random character triplet
          enc = cipher_predict(t);
          add_triplet(mc3_pkg::CMD_DECRYPT, int'(enc.v0), int'(enc.v1), int'(enc.v2));
        end
      endcase
    end
    drain();
  endtask

  initial begin
    key_rows[0] = mc3_pkg::KEY_ROW_ZERO_RST;
    key_rows[1] = mc3_pkg::KEY_ROW_ONE_RST;
    key_rows[2] = mc3_pkg::KEY_ROW_TWO_RST;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset key, letters of both cases, the non-letter borders and decrypt triplets
    add_triplet(mc3_pkg::CMD_ENCRYPT, "A", "B", "C");
    add_triplet(mc3_pkg::CMD_ENCRYPT, "z", "a", "Z");
    add_triplet(mc3_pkg::CMD_ENCRYPT, 64, 91, 96);
    add_triplet(mc3_pkg::CMD_ENCRYPT, 123, -1, 0);
    add_triplet(mc3_pkg::CMD_ENCRYPT, -32768, 32767, "m");
    add_triplet(mc3_pkg::CMD_DECRYPT, 14, 10, 9);
    add_triplet(mc3_pkg::CMD_DECRYPT, 0, 0, 0);
    add_triplet(mc3_pkg::CMD_DECRYPT, -32768, 32767, -1);
    add_triplet(mc3_pkg::CMD_DECRYPT, 32767, 32767, 32767);
    drain();
    // singular key, extreme entries, identity key
    load_key(24'h808080, 24'h808080, 24'h808080);
    add_triplet(mc3_pkg::CMD_ENCRYPT, "Z", "z", "Z");
    add_triplet(mc3_pkg::CMD_DECRYPT, 5, -7, 32767);
    drain();
    load_key(24'h7F7F7F, 24'h80007F, 24'h017F80);
    add_triplet(mc3_pkg::CMD_ENCRYPT, "z", "Z", "z");
    add_triplet(mc3_pkg::CMD_DECRYPT, -32768, -32768, 32767);
    add_triplet(mc3_pkg::CMD_DECRYPT, 1, 2, 3);
    drain();
    load_key(24'h000001, 24'h000100, 24'h010000);
    add_triplet(mc3_pkg::CMD_DECRYPT, 1, 26, 27);
    add_triplet(mc3_pkg::CMD_DECRYPT, 0, -1, 13);
    drain();

    for (int p = 0; p < 6; p++) begin
      logic [mc3_pkg::KEY_W-1:0] r0, r1, r2;
      case (p)
        0: begin
          r0 = mc3_pkg::KEY_ROW_ZERO_RST;
          r1 = mc3_pkg::KEY_ROW_ONE_RST;
          r2 = mc3_pkg::KEY_ROW_TWO_RST;
        end
        1: begin
          r0 = mc3_pkg::KEY_W'($urandom);
          r1 = mc3_pkg::KEY_W'($urandom);
          r2 = r0;
        end
        default: begin
          r0 = mc3_pkg::KEY_W'($urandom);
          r1 = mc3_pkg::KEY_W'($urandom);
          r2 = mc3_pkg::KEY_W'($urandom);
        end
      endcase
      load_key(r0, r1, r2);
      idle_pct = (p == 3) ? 0 : 20;
      random_phase(120);
    end

    if (errors == 0)
      $display("matrix_cipher_3x3_unit regression: pass");
    else
      $display("matrix_cipher_3x3_unit regression: fail");
    $finish;
  end

  initial begin
    #2000000;
    $display("matrix_cipher_3x3_unit regression: fail");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/mc3_pkg.sv
rtl/mc3_inverse.sv
rtl/mc3_pipe.sv
rtl/matrix_cipher_3x3_unit.sv
test/tb_matrix_cipher_3x3_unit.sv
